// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers used by the checker file hexp_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, disabled while reset is active.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: %m");

// Assert a property on the rising clock edge, reset cycles included.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed: %m");

`endif

// ===== design/hexp_pkg.sv =====
// ----------------------------------------------------------------------------
// hexp_pkg
// Types, codes and character classification for the hex text parser.
// ----------------------------------------------------------------------------
package hexp_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       last_result;
  } out_item_t;

  typedef struct packed {
    logic [3:0] high_nibble;
    logic       nibble_waiting;
    logic       zero_held;
    logic       byte_seen;
    logic       failed;
  } parse_state_t;

  typedef enum logic [1:0] {
    STAT_DATA     = 2'd0,
    STAT_END_OK   = 2'd1,
    STAT_BAD_CHAR = 2'd2,
    STAT_NO_BYTES = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CLS_DIGIT = 2'd0,
    CLS_SEP   = 2'd1,
    CLS_BAD   = 2'd2
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  value;
  } char_kind_t;

  // Up to three results per character.
  localparam int MAX_RES = 3;
  localparam int RES_CW  = 2;

  typedef struct packed {
    parse_state_t           st;
    logic [RES_CW-1:0]      count;
    out_item_t [MAX_RES-1:0] res;
  } step_result_t;

  // Result queue.
  localparam int QDEPTH = 8;
  localparam int QAW    = 3;
  localparam int QCW    = 4;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_F    = 8'h66;
  localparam logic [7:0] CH_LO_X    = 8'h78;
  localparam logic [3:0] NIBBLE_TEN = 4'hA;

  function automatic char_kind_t classify(input logic [7:0] c);
    char_kind_t k;
    k.cls   = CLS_BAD;
    k.value = 4'h0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      k.cls   = CLS_DIGIT;
      k.value = c[3:0];
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      k.cls   = CLS_DIGIT;
      k.value = NIBBLE_TEN + 4'(c - CH_UP_A);
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      k.cls   = CLS_DIGIT;
      k.value = NIBBLE_TEN + 4'(c - CH_LO_A);
    end else if ((c >= 8'h09 && c <= 8'h0D) || c == 8'h20 ||
                 (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
                 (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E)) begin
      k.cls = CLS_SEP;
    end
    return k;
  endfunction

  function automatic out_item_t make_item(input logic [7:0] b, input status_t s,
                                          input logic l);
    out_item_t o;
    o.data_byte   = b;
    o.status      = s;
    o.last_result = l;
    return o;
  endfunction

endpackage

// ===== design/hexp_step.sv =====
// ----------------------------------------------------------------------------
// hexp_step
// Single-character parse step: next state and up to three results.
// ----------------------------------------------------------------------------
module hexp_step (
  input  hexp_pkg::parse_state_t st_i,
  input  hexp_pkg::in_item_t     item_i,
  output hexp_pkg::step_result_t res_o
);

  hexp_pkg::parse_state_t            st;
  hexp_pkg::char_kind_t              kind;
  logic [hexp_pkg::RES_CW-1:0]       cnt;
  hexp_pkg::out_item_t [hexp_pkg::MAX_RES-1:0] res;
  logic                              consumed;
  logic                              stop;
  logic                              last;

  always_comb begin
    st       = st_i;
    cnt      = '0;
    res      = '0;
    consumed = 1'b0;
    stop     = 1'b0;
    last     = item_i.last_char;
    kind     = hexp_pkg::classify(item_i.char_code);

    if (st.failed) begin
      // swallow until the last character
      if (last) begin
        st = '0;
      end
    end else begin
      if (st.zero_held) begin
        st.zero_held = 1'b0;
        if (item_i.char_code == hexp_pkg::CH_LO_X) begin
          // prefix: flush any pending nibble, skip the x
          if (st.nibble_waiting) begin
            res[cnt] = hexp_pkg::make_item({4'h0, st.high_nibble},
                                           hexp_pkg::STAT_DATA, 1'b0);
            cnt = cnt + 2'd1;
            st.byte_seen      = 1'b1;
            st.nibble_waiting = 1'b0;
            st.high_nibble    = 4'h0;
          end
          consumed = 1'b1;
        end else if (st.nibble_waiting) begin
          res[cnt] = hexp_pkg::make_item({st.high_nibble, 4'h0},
                                         hexp_pkg::STAT_DATA, 1'b0);
          cnt = cnt + 2'd1;
          st.byte_seen      = 1'b1;
          st.nibble_waiting = 1'b0;
          st.high_nibble    = 4'h0;
        end else begin
          st.high_nibble    = 4'h0;
          st.nibble_waiting = 1'b1;
        end
      end

      if (!consumed) begin
        if (item_i.char_code == hexp_pkg::CH_ZERO && !last) begin
          st.zero_held = 1'b1;
        end else if (kind.cls == hexp_pkg::CLS_DIGIT) begin
          if (st.nibble_waiting) begin
            res[cnt] = hexp_pkg::make_item({st.high_nibble, kind.value},
                                           hexp_pkg::STAT_DATA, 1'b0);
            cnt = cnt + 2'd1;
            st.byte_seen      = 1'b1;
            st.nibble_waiting = 1'b0;
            st.high_nibble    = 4'h0;
          end else begin
            st.high_nibble    = kind.value;
            st.nibble_waiting = 1'b1;
          end
        end else if (kind.cls == hexp_pkg::CLS_SEP) begin
          if (st.nibble_waiting) begin
            res[cnt] = hexp_pkg::make_item({4'h0, st.high_nibble},
                                           hexp_pkg::STAT_DATA, 1'b0);
            cnt = cnt + 2'd1;
            st.byte_seen      = 1'b1;
            st.nibble_waiting = 1'b0;
            st.high_nibble    = 4'h0;
          end
        end else begin
          res[cnt] = hexp_pkg::make_item(8'h00, hexp_pkg::STAT_BAD_CHAR, 1'b1);
          cnt = cnt + 2'd1;
          st        = '0;
          st.failed = !last;
          stop      = 1'b1;
        end
      end

      if (!stop && last) begin
        if (st.nibble_waiting) begin
          res[cnt] = hexp_pkg::make_item({4'h0, st.high_nibble},
                                         hexp_pkg::STAT_DATA, 1'b0);
          cnt = cnt + 2'd1;
          st.byte_seen = 1'b1;
        end
        res[cnt] = hexp_pkg::make_item(8'h00, st.byte_seen ? hexp_pkg::STAT_END_OK
                                                            : hexp_pkg::STAT_NO_BYTES,
                                       1'b1);
        cnt = cnt + 2'd1;
        st  = '0;
      end
    end

    res_o.st    = st;
    res_o.count = cnt;
    res_o.res   = res;
  end

endmodule

// ===== design/hexp_queue.sv =====
// ----------------------------------------------------------------------------
// hexp_queue
// Result queue: takes up to three results a cycle, gives one a cycle.
// ----------------------------------------------------------------------------
module hexp_queue (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic [hexp_pkg::RES_CW-1:0]              push_cnt,
  input  hexp_pkg::out_item_t [hexp_pkg::MAX_RES-1:0] push_items,
  input  logic                                     pop,
  output logic                                     head_vld,
  output hexp_pkg::out_item_t                      head_item,
  output logic [hexp_pkg::QCW-1:0]                 fill
);

  hexp_pkg::out_item_t         mem_r [hexp_pkg::QDEPTH];
  logic [hexp_pkg::QAW-1:0]    head_r, head_nxt;
  logic [hexp_pkg::QAW-1:0]    tail_r, tail_nxt;
  logic [hexp_pkg::QCW-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    head_nxt = head_r + hexp_pkg::QAW'(pop);
    tail_nxt = tail_r + hexp_pkg::QAW'(push_cnt);
    cnt_nxt  = cnt_r + hexp_pkg::QCW'(push_cnt) - hexp_pkg::QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < hexp_pkg::MAX_RES; i++) begin
      if (hexp_pkg::RES_CW'(i) < push_cnt) begin
        mem_r[tail_r + hexp_pkg::QAW'(i)] <= push_items[i];
      end
    end
  end

  assign head_vld  = (cnt_r != '0);
  assign head_item = mem_r[head_r];
  assign fill      = cnt_r;

endmodule

// ===== design/hex_text_to_byte_parser.sv =====
// ----------------------------------------------------------------------------
// hex_text_to_byte_parser
// ASCII hex text to byte stream converter with end-of-text status.
// ----------------------------------------------------------------------------
// One ASCII character enters per beat on the in_ channel; pairs of hex digits
// (0-9, A-F, a-f) leave as bytes on the out_ channel, high nibble first. A
// lone digit before a separator or the end of the text becomes a byte of its
// own. Whitespace and punctuation end a byte, a lowercase 0x prefix is
// skipped and ends a byte too. The last character of a text closes it with
// one status beat (end ok, or no bytes found); an invalid character gives an
// invalid-character status beat at once and the rest of that text, up to its
// last character, is dropped silently. Every status beat carries
// last_result = 1. A '0' is held for one character to look for a following
// 'x', so a byte may appear one character late. Throughput: one character
// per clock as long as the eight-entry result queue has room for three more
// results; the queue drains one result per clock while out_stall is low, so
// a text that produces more than one result per character slows input to the
// output rate. An input beat passes through the input register and the parse
// step into the queue, whose head gives its first result.
// ----------------------------------------------------------------------------
module hex_text_to_byte_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hexp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output hexp_pkg::out_item_t out_item
);

  // Input register
  logic                   in_vld_r;
  hexp_pkg::in_item_t     in_item_r;
  // Parser state
  hexp_pkg::parse_state_t st_r;
  hexp_pkg::step_result_t step;
  logic [hexp_pkg::QCW-1:0] q_fill;
  logic                   advance;
  logic                   pop;

  // Move the registered character through the parse step when the queue
  // can take the worst case of three results.
  assign advance  = in_vld_r &&
                    (q_fill <= hexp_pkg::QCW'(hexp_pkg::QDEPTH - hexp_pkg::MAX_RES));
  assign in_stall = in_vld_r && !advance;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  // Payload: load only on an accepted beat.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
  end

  hexp_step u_step (
    .st_i   (st_r),
    .item_i (in_item_r),
    .res_o  (step)
  );

  // Advance the parser state only when the character is consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= step.st;
    end
  end

  hexp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (advance ? step.count : '0),
    .push_items (step.res),
    .pop        (pop),
    .head_vld   (out_valid),
    .head_item  (out_item),
    .fill       (q_fill)
  );

endmodule

// ===== design/hexp_checker.sv =====
// ----------------------------------------------------------------------------
// hexp_checker
// Port-level checks for the hex text parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hexp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input hexp_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input hexp_pkg::out_item_t out_item
);

  // hold a stalled result beat
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_item))

  // data beats never close a text, status beats always do
  `ASSERT_CLK(a_last_matches_status, clk, rst_n, out_valid |-> (out_item.last_result == (out_item.status != hexp_pkg::STAT_DATA)))

  // status beats carry a zero byte
  `ASSERT_CLK(a_status_byte_zero, clk, rst_n, out_valid && out_item.status != hexp_pkg::STAT_DATA |-> out_item.data_byte == 8'h00)

  // nothing leaves and no input is stalled right after reset
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid && !in_stall)

endmodule

bind hex_text_to_byte_parser hexp_checker u_hexp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
